// File: hdl/slb_pkg.sv
package slb_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned BAR_W   = 10;
    localparam int unsigned CNT_W   = 14;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_ONE   = 3'd0,
        REG_LEVEL_TWO   = 3'd1,
        REG_LEVEL_THREE = 3'd2,
        REG_LEVEL_FOUR  = 3'd3,
        REG_LEVEL_FIVE  = 3'd4,
        REG_MARGIN      = 3'd5,
        REG_FLASH_PER   = 3'd6
    } cfg_reg_t;

    // bar patterns for each band
    localparam logic [BAR_W-1:0] BAR_OFF   = 10'h000;
    localparam logic [BAR_W-1:0] BAR_TWO   = 10'h003;
    localparam logic [BAR_W-1:0] BAR_FOUR  = 10'h00F;
    localparam logic [BAR_W-1:0] BAR_SIX   = 10'h03F;
    localparam logic [BAR_W-1:0] BAR_EIGHT = 10'h0FF;
    localparam logic [BAR_W-1:0] BAR_ALL   = 10'h3FF;

endpackage

// File: hdl/shift_light_bar_with_overrev_flash.sv
// Shift light bar: each transfer on the s_ channel is one update tick carrying
// engine speed, and yields exactly one m_ transfer with the 10-light bar after
// that tick. Five levels fill the bar two lights at a time; at or above level
// five plus the over-rev margin the bar flashes, toggling each time the tick
// counter passes the flash period, with the top pair in opposite phase to the
// lower eight. Throughput is one tick per clock unless m_ready stalls the results;
// a tick passes the input register and then the result register, with the bar,
// flag and counter state updated as it moves between them. Configuration writes
// take effect on the next clock and should be made while the block is idle.
module shift_light_bar_with_overrev_flash #(
    parameter int unsigned COUNTER_WRAP = 10000
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [slb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [slb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // input ticks
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [slb_pkg::SPEED_W-1:0]           s_engine_speed,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [slb_pkg::BAR_W-1:0]             m_light_bar
);

    // configuration registers
    logic [slb_pkg::SPEED_W-1:0] level1_reg, level2_reg, level3_reg, level4_reg, level5_reg;
    logic [slb_pkg::SPEED_W-1:0] margin_reg;
    logic [slb_pkg::CNT_W-1:0]   flash_per_reg;

    // input stage
    logic                        in_valid_reg;
    logic [slb_pkg::SPEED_W-1:0] speed_reg;

    // tick state
    logic [slb_pkg::BAR_W-1:0]   bar_reg, bar_next;
    logic                        flag_reg, flag_next;
    logic [slb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // result stage
    logic                        out_valid_reg;
    logic [slb_pkg::BAR_W-1:0]   out_bar_reg;

    logic                        advance;
    logic [slb_pkg::SPEED_W:0]   limit;
    logic [slb_pkg::SPEED_W:0]   speed_ext;
    logic [slb_pkg::CNT_W-1:0]   cnt_base;
    logic [slb_pkg::CNT_W:0]     cnt_inc;

    // result register frees up when empty or being taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_light_bar = out_bar_reg;

    assign limit     = {1'b0, level5_reg} + {1'b0, margin_reg};
    assign speed_ext = {1'b0, speed_reg};

    // band selection, first match wins
    always_comb begin
        bar_next = bar_reg;
        flag_next = flag_reg;
        cnt_base = cnt_reg;
        priority if (speed_reg >= level1_reg && speed_reg < level2_reg) begin
            bar_next = slb_pkg::BAR_TWO;
            flag_next = 1'b0;
        end else if (speed_reg >= level2_reg && speed_reg < level3_reg) begin
            bar_next = slb_pkg::BAR_FOUR;
            flag_next = 1'b0;
        end else if (speed_reg >= level3_reg && speed_reg < level4_reg) begin
            bar_next = slb_pkg::BAR_SIX;
            flag_next = 1'b0;
        end else if (speed_reg >= level4_reg && speed_reg < level5_reg) begin
            bar_next = slb_pkg::BAR_EIGHT;
            flag_next = 1'b0;
        end else if (speed_reg >= level5_reg && speed_ext < limit) begin
            bar_next = slb_pkg::BAR_ALL;
            flag_next = 1'b0;
        end else if (speed_ext >= limit && cnt_reg > flash_per_reg) begin
            // first flash holds the top pair so it runs out of phase
            if (!flag_reg) begin
                bar_next = bar_reg ^ slb_pkg::BAR_EIGHT;
                flag_next = 1'b1;
            end else begin
                bar_next = bar_reg ^ slb_pkg::BAR_ALL;
            end
            cnt_base = '0;
        end else if (speed_reg < level1_reg) begin
            bar_next = slb_pkg::BAR_OFF;
            flag_next = 1'b0;
        end else begin
            // levels out of order or flash zone waiting: hold
            bar_next = bar_reg;
        end
    end

    // tick counter with wrap, advanced only when a tick moves into the result register
    assign cnt_inc = {1'b0, cnt_base} + {{slb_pkg::CNT_W{1'b0}}, 1'b1};
    assign cnt_next = (cnt_inc > (slb_pkg::CNT_W+1)'(COUNTER_WRAP))
                      ? '0 : cnt_inc[slb_pkg::CNT_W-1:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level1_reg <= '0;
            level2_reg <= '0;
            level3_reg <= '0;
            level4_reg <= '0;
            level5_reg <= '0;
            margin_reg <= '0;
            flash_per_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                slb_pkg::REG_LEVEL_ONE:   level1_reg <= cfg_wdata;
                slb_pkg::REG_LEVEL_TWO:   level2_reg <= cfg_wdata;
                slb_pkg::REG_LEVEL_THREE: level3_reg <= cfg_wdata;
                slb_pkg::REG_LEVEL_FOUR:  level4_reg <= cfg_wdata;
                slb_pkg::REG_LEVEL_FIVE:  level5_reg <= cfg_wdata;
                slb_pkg::REG_MARGIN:      margin_reg <= cfg_wdata;
                slb_pkg::REG_FLASH_PER:   flash_per_reg <= cfg_wdata[slb_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control and tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            bar_reg <= slb_pkg::BAR_OFF;
            flag_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                bar_reg <= bar_next;
                flag_reg <= flag_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            speed_reg <= s_engine_speed;
        end
        if (advance && in_valid_reg) begin
            out_bar_reg <= bar_next;
        end
    end

endmodule

// File: hdl/slb_checker.sv
module slb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [slb_pkg::BAR_W-1:0]      m_light_bar
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_light_bar))
        else $error("result changed while stalled");

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a tick taken into an idle pipe shows up after the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && $past(!m_valid) && $past(!(s_valid && s_ready))
        |-> ##2 m_valid)
        else $error("result missing after accepted tick");

endmodule

bind shift_light_bar_with_overrev_flash slb_checker u_slb_checker (.*);

// File: test/tb_shift_light_bar_with_overrev_flash.sv
module tb_shift_light_bar_with_overrev_flash;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_WRAP       = 10000;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 150;

    // index with no register behind it
    localparam logic [slb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // first flash keeps the top pair, so only the lower eight flip
    localparam logic [slb_pkg::BAR_W-1:0] LOWER_EIGHT = 10'h0FF;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [slb_pkg::CFG_IDX_W-1:0]    idx;
        logic [slb_pkg::CFG_DATA_W-1:0]   val;
        logic                             known;
        logic [slb_pkg::BAR_W-1:0]        bar;
    } dir_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [slb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [slb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [slb_pkg::SPEED_W-1:0]    s_engine_speed = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [slb_pkg::BAR_W-1:0]      m_light_bar;

    // predictor copy of the registers and state
    logic [15:0]               lvl [5];
    logic [15:0]               margin;
    logic [slb_pkg::CNT_W-1:0] fper;
    logic [slb_pkg::BAR_W-1:0] bar_q;
    logic                      flag_q;
    logic [slb_pkg::CNT_W-1:0] cnt_q;

    logic [slb_pkg::BAR_W-1:0] pending_bars [$];
    logic [slb_pkg::BAR_W-1:0] want_bar;
    dir_row_t                  dir_rows [$];
    int                        err_count = 0;
    int                        cycle_count = 0;
    int                        src_idle_pct = 0;
    int                        sink_stall_pct = 0;

    shift_light_bar_with_overrev_flash #(
        .COUNTER_WRAP (TICK_WRAP)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_engine_speed (s_engine_speed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_light_bar    (m_light_bar)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bar after one tick; advances the predictor state
    function automatic logic [slb_pkg::BAR_W-1:0] next_bar(input logic [15:0] spd);
        logic [16:0] limit;
        logic [14:0] nxt;
        limit = {1'b0, lvl[4]} + {1'b0, margin};
        if (spd >= lvl[0] && spd < lvl[1]) begin
            bar_q = slb_pkg::BAR_TWO;
            flag_q = 1'b0;
        end else if (spd >= lvl[1] && spd < lvl[2]) begin
            bar_q = slb_pkg::BAR_FOUR;
            flag_q = 1'b0;
        end else if (spd >= lvl[2] && spd < lvl[3]) begin
            bar_q = slb_pkg::BAR_SIX;
            flag_q = 1'b0;
        end else if (spd >= lvl[3] && spd < lvl[4]) begin
            bar_q = slb_pkg::BAR_EIGHT;
            flag_q = 1'b0;
        end else if (spd >= lvl[4] && {1'b0, spd} < limit) begin
            bar_q = slb_pkg::BAR_ALL;
            flag_q = 1'b0;
        end else if ({1'b0, spd} >= limit && cnt_q > fper) begin
            if (!flag_q) begin
                bar_q = bar_q ^ LOWER_EIGHT;
                flag_q = 1'b1;
            end else begin
                bar_q = ~bar_q;
            end
            cnt_q = '0;
        end else if (spd < lvl[0]) begin
            bar_q = slb_pkg::BAR_OFF;
            flag_q = 1'b0;
        end
        // free-running tick counter with wrap
        nxt = {1'b0, cnt_q} + 15'd1;
        if (nxt > TICK_WRAP)
            nxt = '0;
        cnt_q = nxt[slb_pkg::CNT_W-1:0];
        return bar_q;
    endfunction

    // one register write, mirrored into the predictor
    task automatic write_reg(input logic [slb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            slb_pkg::REG_LEVEL_ONE:   lvl[0] = val;
            slb_pkg::REG_LEVEL_TWO:   lvl[1] = val;
            slb_pkg::REG_LEVEL_THREE: lvl[2] = val;
            slb_pkg::REG_LEVEL_FOUR:  lvl[3] = val;
            slb_pkg::REG_LEVEL_FIVE:  lvl[4] = val;
            slb_pkg::REG_MARGIN:      margin = val;
            slb_pkg::REG_FLASH_PER:   fper = val[slb_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // offer one tick, wait for the transfer, then log its bar
    task automatic send_tick(input logic [15:0] spd, input logic known,
                             input logic [slb_pkg::BAR_W-1:0] typed_bar);
        logic [slb_pkg::BAR_W-1:0] pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_engine_speed <= spd;
        do @(posedge aclk); while (!s_ready);
        pred = next_bar(spd);
        pending_bars.push_back(known ? typed_bar : pred);
    endtask

    // drop valid and let every outstanding bar come out
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_random(input int ph);
        int base;
        int pick;
        logic [15:0] lv [5];
        logic [15:0] mg;
        logic [15:0] fp;
        // levels: extremes first, then mostly ascending, sometimes scrambled
        if (ph == 0) begin
            foreach (lv[k]) lv[k] = 16'h0000;
        end else if (ph == 1) begin
            foreach (lv[k]) lv[k] = 16'hFFFF;
        end else if ($urandom_range(0, 3) == 0) begin
            foreach (lv[k]) lv[k] = 16'($urandom);
        end else begin
            base = $urandom_range(0, 20000);
            foreach (lv[k]) begin
                if (base > 65535)
                    base = 65535;
                lv[k] = 16'(base);
                base = base + $urandom_range(0, 8000);
            end
        end
        pick = $urandom_range(0, 5);
        if (ph == 0 || pick == 0)
            mg = 16'h0000;
        else if (ph == 1 || pick == 1)
            mg = 16'hFFFF;
        else
            mg = 16'($urandom_range(0, 3000));
        if (ph == 0)
            fp = 16'h0000;
        else if ($urandom_range(0, 4) == 0)
            fp = 16'($urandom);
        else
            fp = 16'($urandom_range(0, 12));
        write_reg(slb_pkg::REG_LEVEL_ONE, lv[0]);
        write_reg(slb_pkg::REG_LEVEL_TWO, lv[1]);
        write_reg(slb_pkg::REG_LEVEL_THREE, lv[2]);
        write_reg(slb_pkg::REG_LEVEL_FOUR, lv[3]);
        write_reg(slb_pkg::REG_LEVEL_FIVE, lv[4]);
        write_reg(slb_pkg::REG_MARGIN, mg);
        write_reg(slb_pkg::REG_FLASH_PER, fp);
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // speeds clustered around the thresholds, plus extremes and noise
    function automatic logic [15:0] pick_speed();
        int pick;
        int sel;
        int base;
        int v;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        if (pick <= 2)
            return 16'($urandom);
        sel = $urandom_range(0, 5);
        base = (sel == 5) ? int'(lvl[4]) + int'(margin) : int'(lvl[sel]);
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bars.size() == 0) begin
                $display("%0t: unexpected result transfer, light_bar %h", $time, m_light_bar);
                err_count++;
            end else begin
                want_bar = pending_bars.pop_front();
                if (m_light_bar !== want_bar) begin
                    $display("%0t: light_bar mismatch: expected %h, actual %h",
                             $time, want_bar, m_light_bar);
                    err_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("tb_shift_light_bar_with_overrev_flash: FAIL");
        $finish;
    end

    initial begin
        foreach (lvl[k]) lvl[k] = '0;
        margin = '0;
        fper = '0;
        bar_q = slb_pkg::BAR_OFF;
        flag_q = 1'b0;
        cnt_q = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; reset registers first: all levels zero, no level band matches, ticks sit in the flash zone
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd0, 1'b1, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        // ordered levels; flash period written with stray upper bits
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_LEVEL_ONE, 16'd100, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_LEVEL_TWO, 16'd200, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_LEVEL_THREE, 16'd300, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_LEVEL_FOUR, 16'd400, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_LEVEL_FIVE, 16'd500, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_MARGIN, 16'd100, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_FLASH_PER, 16'hC002, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_CFG, REG_UNUSED, 16'hFFFF, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd99, 1'b1, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd100, 1'b1, slb_pkg::BAR_TWO});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd199, 1'b1, slb_pkg::BAR_TWO});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd200, 1'b1, slb_pkg::BAR_FOUR});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd300, 1'b1, slb_pkg::BAR_SIX});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd400, 1'b1, slb_pkg::BAR_EIGHT});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd500, 1'b1, slb_pkg::BAR_ALL});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd599, 1'b1, slb_pkg::BAR_ALL});
        // flash zone: first flash offsets the top pair, then full toggles
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd600, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd600, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd600, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd0, 1'b1, slb_pkg::BAR_OFF});
        // limit sum wider than 16 bits: top speed stays in the full band
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_MARGIN, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b1, slb_pkg::BAR_ALL});
        // zero margin: level five itself is the flash limit
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_MARGIN, 16'd0, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd500, 1'b0, slb_pkg::BAR_OFF});
        // period above the wrap: bar holds
        dir_rows.push_back('{ROW_CFG, slb_pkg::REG_FLASH_PER, 16'hFFFF, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});
        dir_rows.push_back('{ROW_TICK, slb_pkg::REG_LEVEL_ONE, 16'd65535, 1'b0, slb_pkg::BAR_OFF});

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_tick(dir_rows[r].val, dir_rows[r].known, dir_rows[r].bar);
            end
        end

        // random phases, rotating through the idle patterns
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            program_random(ph);
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 75;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 75;
                end
                default: begin
                    src_idle_pct = 6;
                    sink_stall_pct = 6;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_tick(pick_speed(), 1'b0, slb_pkg::BAR_OFF);
        end

        settle();
        if (err_count == 0) begin
            $display("tb_shift_light_bar_with_overrev_flash: PASS");
        end else begin
            $display("tb_shift_light_bar_with_overrev_flash: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/slb_pkg.sv
hdl/shift_light_bar_with_overrev_flash.sv
hdl/slb_checker.sv
test/tb_shift_light_bar_with_overrev_flash.sv
